/* rtl/core/stbl_pkg.sv */
// Shared types and codes for the sorted table unit.
// Holds operation and result codes, the controller state type and the
// command/status structs that join the controller and the datapath.
package stbl_pkg;

  // operation codes carried on the input tuser
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_FIND   = 2'd2;

  // field widths fixed by the word formats
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 16;
  localparam int unsigned FieldW = 5;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // index code reported when no entry matches
  localparam logic [FieldW-1:0] NOT_FOUND = '1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } stbl_status_e;

  // controller states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_INS_CHK  = 8'b0000_0010,
    ST_INS_CMP  = 8'b0000_0100,
    ST_DEL_CHK  = 8'b0000_1000,
    ST_DEL_MOV  = 8'b0001_0000,
    ST_FIND_CHK = 8'b0010_0000,
    ST_FIND_CMP = 8'b0100_0000,
    ST_RESULT   = 8'b1000_0000
  } stbl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic         load;       // capture the input word, set up the index
    logic         rd;         // read one entry into the read register
    logic         wr_shift;   // move the read entry to the index, step index
    logic         wr_val;     // write the new value at the index
    logic         idx_inc;    // step the find index
    logic         cnt_inc;
    logic         cnt_dec;
    logic         out_load;   // load the result word
    stbl_status_e out_status;
    logic         out_found;
  } stbl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] in_mode;
    logic       full;       // table holds capacity entries
    logic       pos_bad;    // delete position outside 1..count
    logic       idx_zero;
    logic       less;       // read entry is smaller than the value
    logic       equal;      // read entry equals the key
    logic       at_count;   // index reached the entry count
    logic       del_last;   // index is the last stored entry
    logic       out_free;   // result register can take a word
  } stbl_stat_t;

endpackage

/* rtl/core/stbl_ctrl.sv */
// Controller state machine of the sorted table unit.
// Sequences the insert, delete and find walks; depends on stbl_pkg.
module stbl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  stbl_pkg::stbl_stat_t stat_i,
  output stbl_pkg::stbl_cmd_t  cmd_o
);
  import stbl_pkg::*;

  stbl_state_e  st_q, st_d;
  stbl_status_e res_q, res_d;
  logic         found_q, found_d;

  // next state and commands
  always_comb begin
    st_d    = st_q;
    res_d   = res_q;
    found_d = found_q;
    cmd_o   = '0;
    cmd_o.out_status = res_q;
    cmd_o.out_found  = found_q;
    s_axis_tready = 1'b0;
    case (st_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          found_d = 1'b0;
          res_d   = STAT_DONE;
          case (stat_i.in_mode)
            MODE_INSERT: begin
              if (stat_i.full) begin
                res_d = STAT_FULL;
                st_d  = ST_RESULT;
              end else begin
                st_d = ST_INS_CHK;
              end
            end
            MODE_DELETE: begin
              if (stat_i.pos_bad) begin
                res_d = STAT_RANGE;
                st_d  = ST_RESULT;
              end else begin
                st_d = ST_DEL_CHK;
              end
            end
            MODE_FIND: st_d = ST_FIND_CHK;
            default:   st_d = ST_RESULT;
          endcase
        end
      end
      // walk down from the end, shifting smaller entries up
      ST_INS_CHK: begin
        if (stat_i.idx_zero) begin
          cmd_o.wr_val  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          st_d = ST_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          st_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (stat_i.less) begin
          cmd_o.wr_shift = 1'b1;
          st_d = ST_INS_CHK;
        end else begin
          cmd_o.wr_val  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          st_d = ST_RESULT;
        end
      end
      // close the gap left by the removed entry
      ST_DEL_CHK: begin
        if (stat_i.del_last) begin
          cmd_o.cnt_dec = 1'b1;
          st_d = ST_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          st_d = ST_DEL_MOV;
        end
      end
      ST_DEL_MOV: begin
        cmd_o.wr_shift = 1'b1;
        st_d = ST_DEL_CHK;
      end
      // linear search from the top
      ST_FIND_CHK: begin
        if (stat_i.at_count) begin
          st_d = ST_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          st_d = ST_FIND_CMP;
        end
      end
      ST_FIND_CMP: begin
        if (stat_i.equal) begin
          found_d = 1'b1;
          st_d = ST_RESULT;
        end else begin
          cmd_o.idx_inc = 1'b1;
          st_d = ST_FIND_CHK;
        end
      end
      // hand the result word over once the output register is free
      ST_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      res_q   <= STAT_DONE;
      found_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      res_q   <= res_d;
      found_q <= found_d;
    end
  end

endmodule

/* rtl/core/stbl_dp.sv */
// Datapath of the sorted table unit: entry memory, index and count
// registers, compare logic and the result register; depends on stbl_pkg.
module stbl_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [stbl_pkg::InDataW-1:0]    in_data_i,
  input  logic [1:0]                      in_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stbl_pkg::OutDataW-1:0]   out_data_o,
  input  stbl_pkg::stbl_cmd_t             cmd_i,
  output stbl_pkg::stbl_stat_t            stat_o
);
  import stbl_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = (CW > FieldW) ? CW : FieldW;

  logic [ValueW-1:0]  mem [CAPACITY];
  logic [ValueW-1:0]  rd_q;
  logic [1:0]         mode_q;
  logic [ValueW-1:0]  val_q;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic               out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [ValueW-1:0]  in_value;
  logic [PosW-1:0]    in_pos;
  logic [CW-1:0]      rd_idx;
  logic [EW-1:0]      idx_ext;
  logic [EW-1:0]      cnt_ext;
  logic [FieldW-1:0]  found_idx;

  assign in_value = in_data_i[ValueW-1:0];
  assign in_pos   = in_data_i[ValueW +: PosW];

  // status toward the controller
  assign stat_o.in_mode  = in_mode_i;
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.pos_bad  = (in_pos == '0) || (in_pos > PosW'(count_q));
  assign stat_o.idx_zero = (idx_q == '0);
  assign stat_o.less     = ($signed(rd_q) < $signed(val_q));
  assign stat_o.equal    = (rd_q == val_q);
  assign stat_o.at_count = (idx_q == count_q);
  assign stat_o.del_last = (CW'(idx_q + 1'b1) == count_q);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // read neighbor: below for insert, above for delete, own slot for find
  always_comb begin
    case (mode_q)
      MODE_INSERT: rd_idx = idx_q - 1'b1;
      MODE_DELETE: rd_idx = idx_q + 1'b1;
      default:     rd_idx = idx_q;
    endcase
  end

  // entry memory with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_shift) begin
      mem[idx_q[AW-1:0]] <= rd_q;
    end else if (cmd_i.wr_val) begin
      mem[idx_q[AW-1:0]] <= val_q;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[rd_idx[AW-1:0]];
    end
  end

  // walk index
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      case (in_mode_i)
        MODE_INSERT: idx_d = count_q;
        MODE_DELETE: idx_d = CW'(in_pos - 1'b1);
        default:     idx_d = '0;
      endcase
    end else if (cmd_i.wr_shift) begin
      idx_d = (mode_q == MODE_INSERT) ? idx_q - 1'b1 : idx_q + 1'b1;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  // entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  // command word and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      val_q  <= in_value;
    end
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result word fields, indexes and counts reported modulo 32
  assign idx_ext   = EW'(idx_q);
  assign cnt_ext   = EW'(count_q);
  assign found_idx = cmd_i.out_found ? idx_ext[FieldW-1:0] : NOT_FOUND;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {4'b0, cnt_ext[FieldW-1:0], found_idx, cmd_i.out_status};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/sorted_table_insert_delete_find_unit.sv */
// Top level of the sorted table unit: joins controller and datapath.
// Depends on stbl_pkg, stbl_ctrl and stbl_dp.
//
// Keeps up to CAPACITY signed 32-bit values in descending order. A word on
// the input stream is one command: insert (before the first smaller entry,
// so equal values keep arrival order; dropped with status full when the
// table is full), delete at a 1-based position (status range when outside
// 1..count), or find (0-based index of the first equal entry, else -1).
// Each command returns exactly one result word with the status, the found
// index and the entry count after the command, both taken modulo 32. The
// entries sit in a single-port-read, single-port-write memory, and every
// walk step is a registered read, then a compare or move. A result that is
// not taken holds the controller until the output register frees up. The
// next command is taken while a result still waits in the output register.
module sorted_table_insert_delete_find_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave: tdata = value[31:0], position[47:32]; tuser = mode[1:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  // master: tdata = status[1:0], found_index[6:2], entry_count[11:7], zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);
  import stbl_pkg::*;

  stbl_cmd_t  cmd;
  stbl_stat_t stat;

  stbl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  stbl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
